// File: rtl/rgb24_to_yuv420_planar_defines.svh
// Assertion macros for the RGB24 to planar YUV 4:2:0 converter.
`ifndef RGB24_TO_YUV420_PLANAR_DEFINES_SVH
`define RGB24_TO_YUV420_PLANAR_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, masked while reset is high
`define RGB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb24_to_yuv420_planar: assertion failed");
// clocked check, live through reset as well
`define RGB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rgb24_to_yuv420_planar: assertion failed");
`else
`define RGB_ASSERT(label, clk, rst, prop)
`define RGB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/rgb2yuv_pkg.sv
// Shared types, constants and color math for the RGB24 to YUV 4:2:0 converter.
`timescale 1ns / 1ps
package rgb2yuv_pkg;

   // config register geometry
   localparam int CFG_W           = 13;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int MAX_DIM_DEFAULT = 4096;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   // register index, taken from the word address bit
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // output offset widths
   localparam int LUMA_OFF_W   = 24;
   localparam int CHROMA_OFF_W = 25;

   // color sums fit in 18 signed bits
   localparam int SUM_W = 18;

   typedef enum logic [1:0] {
      CHROMA_NONE = 2'd0,
      CHROMA_U    = 2'd1,
      CHROMA_V    = 2'd2
   } chroma_kind_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0]              luma;
      logic [LUMA_OFF_W-1:0]   luma_offset;
      chroma_kind_type         chroma_kind;
      logic [7:0]              chroma;
      logic [CHROMA_OFF_W-1:0] chroma_offset;
      logic                    frame_end;
   } yuv_type;

   // floor((sum + 128) / 256) + bias, clamped to a byte
   function automatic logic [7:0] scale_byte(input logic signed [SUM_W-1:0] sum,
                                             input logic signed [10:0] bias);
      logic signed [SUM_W-1:0] t;
      logic signed [SUM_W-9:0] q;
      logic signed [SUM_W-8:0] v;
      logic [7:0]              res;
      t = sum + 18'sd128;
      q = t[SUM_W-1:8];
      v = $signed({q[SUM_W-9], q}) + bias;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/rgb24_to_yuv420_planar.sv
// An accepted pixel enters the input register, then the result register that drives rsp_.
// Throughput: one pixel per clock unless rsp_ready stalls; both registers hold one item each.
// Frame area and chroma plane bases are registered in the cycle after a config write.
// Reset (synchronous, active high) empties both stages, zeroes all position counters
// and loads frame_width = 640, frame_height = 480.
`timescale 1ns / 1ps
`include "rgb24_to_yuv420_planar_defines.svh"
// Top level: streaming RGB24 to planar I420 converter with APB-style config port.
module rgb24_to_yuv420_planar #(
   parameter int MAX_DIM = rgb2yuv_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rgb2yuv_pkg::pixel_type               req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rgb2yuv_pkg::yuv_type                 rsp_yuv,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rgb2yuv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rgb2yuv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rgb2yuv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready
);
   import rgb2yuv_pkg::*;

   localparam int DIM_W   = (CFG_W > $clog2(MAX_DIM + 1)) ? CFG_W : $clog2(MAX_DIM + 1);
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int PROD_W  = 2 * DIM_W;
   localparam int AREA5_W = PROD_W + 3;

   // config registers
   logic [CFG_W-1:0] width_cfg_ff;
   logic [CFG_W-1:0] height_cfg_ff;
   logic             csr_write;

   // saturated sizes and plane bases
   logic [DIM_W-1:0]        w_ext, h_ext, w_sat, h_sat;
   logic [PROD_W-1:0]       area;
   logic [AREA5_W-1:0]      area5;
   logic [CHROMA_OFF_W-1:0] u_base_ff, u_base_in;
   logic [CHROMA_OFF_W-1:0] v_base_ff, v_base_in;

   // pipeline stages
   logic      in_valid_ff;
   pixel_type in_pixel_ff;
   logic      rsp_valid_ff;
   yuv_type   rsp_yuv_ff, rsp_yuv_in;
   logic      adv;

   // frame position
   logic [CNT_W-1:0]        col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0]        row_cnt_ff, row_cnt_in;
   logic [LUMA_OFF_W-1:0]   pix_cnt_ff, pix_cnt_in;
   logic [CHROMA_OFF_W-1:0] u_cnt_ff, u_cnt_in;
   logic [CHROMA_OFF_W-1:0] v_cnt_ff, v_cnt_in;
   logic                    last_col, last_row;

   // color math
   logic signed [SUM_W-1:0] r_s, g_s, b_s;
   logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

   // config port
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (paddr[CSR_ADDR_W-1])
            REG_FRAME_WIDTH:  width_cfg_ff  <= pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_cfg_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1])
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(width_cfg_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(height_cfg_ff);
         default:          prdata = '0;
      endcase
   end

   // clip sizes to 2..MAX_DIM
   always_comb begin
      w_ext = DIM_W'(width_cfg_ff);
      h_ext = DIM_W'(height_cfg_ff);
      if (w_ext < DIM_W'(2)) w_sat = DIM_W'(2);
      else if (w_ext > DIM_W'(MAX_DIM)) w_sat = DIM_W'(MAX_DIM);
      else w_sat = w_ext;
      if (h_ext < DIM_W'(2)) h_sat = DIM_W'(2);
      else if (h_ext > DIM_W'(MAX_DIM)) h_sat = DIM_W'(MAX_DIM);
      else h_sat = h_ext;
   end

   // U plane at area, V plane at area*5/4 (bits above the offset width drop out)
   assign area      = PROD_W'(w_sat) * PROD_W'(h_sat);
   assign area5     = AREA5_W'(area) + (AREA5_W'(area) << 2);
   assign u_base_in = area[CHROMA_OFF_W-1:0];
   assign v_base_in = area5[CHROMA_OFF_W+1:2];

   always_ff @(posedge clock) begin
      u_base_ff <= u_base_in;
      v_base_ff <= v_base_in;
   end

   // handshake: stage 1 moves on when the result register is free or drains
   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_yuv   = rsp_yuv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (!rsp_valid_ff || rsp_ready) rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_pixel_ff <= req_pixel;
      if (adv) rsp_yuv_ff <= rsp_yuv_in;
   end

   // color sums
   always_comb begin
      r_s   = $signed({{(SUM_W-8){1'b0}}, in_pixel_ff.red});
      g_s   = $signed({{(SUM_W-8){1'b0}}, in_pixel_ff.green});
      b_s   = $signed({{(SUM_W-8){1'b0}}, in_pixel_ff.blue});
      y_sum = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s;
      u_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s;
      v_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;
   end

   // result and next frame position
   always_comb begin
      last_col = DIM_W'(col_cnt_ff) >= (w_sat - DIM_W'(1));
      last_row = DIM_W'(row_cnt_ff) >= (h_sat - DIM_W'(1));

      rsp_yuv_in.luma          = scale_byte(y_sum, 11'sd16);
      rsp_yuv_in.luma_offset   = pix_cnt_ff;
      rsp_yuv_in.chroma_kind   = CHROMA_NONE;
      rsp_yuv_in.chroma        = 8'd0;
      rsp_yuv_in.chroma_offset = '0;
      rsp_yuv_in.frame_end     = last_col && last_row;

      u_cnt_in = u_cnt_ff;
      v_cnt_in = v_cnt_ff;
      if (!col_cnt_ff[0] && !row_cnt_ff[0]) begin
         rsp_yuv_in.chroma_kind   = CHROMA_U;
         rsp_yuv_in.chroma        = scale_byte(u_sum, 11'sd128);
         rsp_yuv_in.chroma_offset = u_base_ff + u_cnt_ff;
         u_cnt_in                 = u_cnt_ff + 1'b1;
      end else if (!col_cnt_ff[0]) begin
         rsp_yuv_in.chroma_kind   = CHROMA_V;
         rsp_yuv_in.chroma        = scale_byte(v_sum, 11'sd128);
         rsp_yuv_in.chroma_offset = v_base_ff + v_cnt_ff;
         v_cnt_in                 = v_cnt_ff + 1'b1;
      end

      pix_cnt_in = pix_cnt_ff + 1'b1;
      col_cnt_in = col_cnt_ff + 1'b1;
      row_cnt_in = row_cnt_ff;
      if (last_col) begin
         col_cnt_in = '0;
         if (last_row) begin
            row_cnt_in = '0;
            pix_cnt_in = '0;
            u_cnt_in   = '0;
            v_cnt_in   = '0;
         end else begin
            row_cnt_in = row_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         pix_cnt_ff <= '0;
         u_cnt_ff   <= '0;
         v_cnt_ff   <= '0;
      end else if (adv) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         pix_cnt_ff <= pix_cnt_in;
         u_cnt_ff   <= u_cnt_in;
         v_cnt_ff   <= v_cnt_in;
      end
   end

   // checks
   `RGB_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_valid && !in_valid_ff)
   `RGB_ASSERT(a_stall_means_full, clock, reset, !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
   `RGB_ASSERT(a_frame_wrap, clock, reset, (adv && last_col && last_row) |=> (col_cnt_ff == '0 && row_cnt_ff == '0 && pix_cnt_ff == '0 && u_cnt_ff == '0 && v_cnt_ff == '0))
   `RGB_ASSERT(a_no_chroma_zero, clock, reset, (rsp_valid_ff && rsp_yuv_ff.chroma_kind == CHROMA_NONE) |-> (rsp_yuv_ff.chroma == 8'd0 && rsp_yuv_ff.chroma_offset == '0))

endmodule

// File: tb/yuv420_checker.sv
`timescale 1ns / 1ps
// Result checker for the RGB24 to planar YUV 4:2:0 converter: predicts each result and compares.
module yuv420_checker
   import rgb2yuv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  pixel_type             req_pixel,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  yuv_type               rsp_yuv,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    outstanding
);

   // shadow of the size registers and the raster position
   logic [CFG_W-1:0] width_cfg;
   logic [CFG_W-1:0] height_cfg;
   int unsigned      col_pos;
   int unsigned      row_pos;
   int unsigned      luma_count;
   int unsigned      u_count;
   int unsigned      v_count;
   yuv_type          expected_yuv[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // size registers are clamped to 2..MAX_DIM before use
   function automatic int unsigned bound_dim(input logic [CFG_W-1:0] dim);
      if (dim < 2) return 2;
      if (dim > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return dim;
   endfunction

   // round, floor-shift by 8, add bias, clamp to a byte
   function automatic logic [7:0] to_byte(input int sum, input int bias);
      int v;
      v = ((sum + 128) >>> 8) + bias;
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // color conversion plus I420 placement; advances the raster position
   function automatic yuv_type convert_pixel(input pixel_type px);
      int          r, g, b;
      int unsigned w, h, area;
      logic        last_col, last_row;
      yuv_type     y;
      r    = px.red;
      g    = px.green;
      b    = px.blue;
      w    = bound_dim(width_cfg);
      h    = bound_dim(height_cfg);
      area = w * h;
      y    = '0;
      y.luma        = to_byte(66 * r + 129 * g + 25 * b, 16);
      y.luma_offset = LUMA_OFF_W'(luma_count);
      y.chroma_kind = CHROMA_NONE;
      if (col_pos[0] == 1'b0) begin
         if (row_pos[0] == 1'b0) begin
            y.chroma_kind   = CHROMA_U;
            y.chroma        = to_byte(-38 * r - 74 * g + 112 * b, 128);
            y.chroma_offset = CHROMA_OFF_W'(area + u_count);
            u_count++;
         end else begin
            y.chroma_kind   = CHROMA_V;
            y.chroma        = to_byte(112 * r - 94 * g - 18 * b, 128);
            y.chroma_offset = CHROMA_OFF_W'(area * 5 / 4 + v_count);
            v_count++;
         end
      end
      // a shrunken size ends the row or frame at once
      last_col = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      luma_count++;
      if (last_col) begin
         col_pos = 0;
         if (last_row) begin
            row_pos    = 0;
            luma_count = 0;
            u_count    = 0;
            v_count    = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      y.frame_end = last_col && last_row;
      return y;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      yuv_type want;
      if (reset) begin
         width_cfg  = WIDTH_RESET;
         height_cfg = HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         luma_count = 0;
         u_count    = 0;
         v_count    = 0;
         expected_yuv.delete();
      end else begin
         // CSR write lands on the access cycle
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1] == REG_FRAME_WIDTH) begin
               width_cfg = pwdata[CFG_W-1:0];
            end else begin
               height_cfg = pwdata[CFG_W-1:0];
            end
         end
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (expected_yuv.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               want = expected_yuv.pop_front();
               check_field("luma", want.luma, rsp_yuv.luma);
               check_field("luma_offset", want.luma_offset, rsp_yuv.luma_offset);
               check_field("chroma_kind", want.chroma_kind, rsp_yuv.chroma_kind);
               check_field("chroma", want.chroma, rsp_yuv.chroma);
               check_field("chroma_offset", want.chroma_offset, rsp_yuv.chroma_offset);
               check_field("frame_end", want.frame_end, rsp_yuv.frame_end);
            end
         end
         if (req_valid && req_ready) begin
            expected_yuv.push_back(convert_pixel(req_pixel));
         end
      end
      outstanding = expected_yuv.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB24 to planar YUV 4:2:0 converter: stimulus, CSR setup and verdict.
module tb;
   import rgb2yuv_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   pixel_type             req_pixel   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   yuv_type               rsp_yuv;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    outstanding;

   // idle profile; the receiver one is read at clock edges
   int                    tx_idle_pct = 0;
   int                    rx_idle_pct = 0;
   logic                  hold_req    = 1'b0;
   logic                  hold_ack    = 1'b0;
   int                    hold_left   = 0;
   int unsigned           cycle_count = 0;

   always #5 clock = ~clock;

   rgb24_to_yuv420_planar dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_yuv   (rsp_yuv),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   yuv420_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_pixel   (req_pixel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_yuv     (rsp_yuv),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // result side: random backpressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      // the checker counts an item taken at this edge only after the edge settles
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // setup then access cycle; the bus goes idle again before the next use
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly tiny frames, some medium, out-of-range and full-size ones
   function automatic logic [CSR_DATA_W-1:0] random_dim();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return $urandom_range(9, 2);
      if (sel < 75) return $urandom_range(64, 10);
      if (sel < 85) return $urandom_range(1, 0);
      if (sel < 95) return $urandom;
      return MAX_DIM_DEFAULT;
   endfunction

   // run-away guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [23:0] corner_rgb [0:12];
      int          sent;
      int          burst;
      logic        hold_done;
      corner_rgb = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                     24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080,
                     24'h010101, 24'hFEFEFE, 24'h55AA55, 24'hAA55AA};
      sent      = 0;
      hold_done = 1'b0;
      tx_idle_pct = 27;
      rx_idle_pct <= 78;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size 640x480: extremes of the components
      for (int i = 0; i < 3; i++) send_pixel(pixel_type'(corner_rgb[i]));
      drain_results();
      // sizes below range clamp to 2x2; the shrink also ends the current row
      csr_write(WIDTH_ADDR, 1);
      csr_write(HEIGHT_ADDR, 0);
      for (int i = 3; i < 9; i++) send_pixel(pixel_type'(corner_rgb[i]));
      drain_results();
      // sizes above range clamp to 4096x4096: large plane offsets
      csr_write(WIDTH_ADDR, 8191);
      csr_write(HEIGHT_ADDR, 32'hFFFF_FFFF);
      for (int i = 9; i < 13; i++) send_pixel(pixel_type'(corner_rgb[i]));
      drain_results();
      // upper data bits are dropped: 3x3, shrunk mid-frame
      csr_write(WIDTH_ADDR, 32'hFFFF_E003);
      csr_write(HEIGHT_ADDR, 3);
      repeat (9) send_pixel(pixel_type'($urandom));
      drain_results();

      // random frames, reconfigured between bursts
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            tx_idle_pct = 27;
            rx_idle_pct <= 78;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 78;
            rx_idle_pct <= 27;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
            // receiver holds off while pixels keep coming
            if (!hold_done) begin
               hold_req  <= ~hold_req;
               hold_done = 1'b1;
            end
         end
         if ($urandom_range(9) < 8) csr_write(WIDTH_ADDR, random_dim());
         if ($urandom_range(9) < 8) csr_write(HEIGHT_ADDR, random_dim());
         burst = $urandom_range(160, 40);
         repeat (burst) begin
            send_pixel(pixel_type'($urandom));
            sent++;
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rgb2yuv_pkg.sv
rtl/rgb24_to_yuv420_planar.sv
tb/yuv420_checker.sv
tb/tb.sv
